### design/cfir_pkg.sv
package cfir_pkg;

	// Field widths
	localparam int DATA_W = 16;
	localparam int PROD_W = 32;
	localparam int CSUM_W = 33;
	localparam int ACC_W  = 40;
	localparam int CFG_W  = 7;
	localparam int IDX_W  = 6;

	// Number of distinct tap_index codes
	localparam int IDX_SPAN = 2 ** IDX_W;

	// Request command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	typedef logic signed [DATA_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [CSUM_W-1:0] csum_t;
	typedef logic signed [ACC_W-1:0]  acc_t;

	// Per-cycle control shared by every cell of the chain
	typedef struct packed {
		logic advance; // pipeline moves this cycle
		logic push;    // delay line shifts by one sample
		logic clear;   // delay line is zeroed
	} ctl_t;

endpackage

### design/cfir_cell.sv
module cfir_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  cfir_pkg::ctl_t  ctl,
	input  cfir_pkg::sample_t x_in_re,
	input  cfir_pkg::sample_t x_in_im,
	output cfir_pkg::sample_t x_re,
	output cfir_pkg::sample_t x_im,
	input  logic            tap_we,
	input  cfir_pkg::sample_t tap_wr_re,
	input  cfir_pkg::sample_t tap_wr_im,
	input  logic            use_tap,
	output cfir_pkg::csum_t prod_re,
	output cfir_pkg::csum_t prod_im
);

	cfir_pkg::sample_t x_re_q, x_im_q;
	cfir_pkg::sample_t tap_re_q, tap_im_q;
	cfir_pkg::sample_t hr, hi;
	cfir_pkg::prod_t   rr_s1, ii_s1, ri_s1, ir_s1;
	cfir_pkg::csum_t   re_s2, im_s2;

	// Delay element: takes the neighbour's sample on a shift, zeroed after a frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_re_q <= '0;
			x_im_q <= '0;
		end else if (ctl.push) begin
			x_re_q <= x_in_re;
			x_im_q <= x_in_im;
		end else if (ctl.clear) begin
			x_re_q <= '0;
			x_im_q <= '0;
		end
	end

	// Tap coefficient
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_re_q <= '0;
			tap_im_q <= '0;
		end else if (tap_we) begin
			tap_re_q <= tap_wr_re;
			tap_im_q <= tap_wr_im;
		end
	end

	// Taps beyond the count in use contribute nothing
	assign hr = use_tap ? tap_re_q : '0;
	assign hi = use_tap ? tap_im_q : '0;

	// Partial products, then complex combine
	always_ff @(posedge clk) begin
		if (ctl.advance) begin
			rr_s1 <= hr * x_re_q;
			ii_s1 <= hi * x_im_q;
			ri_s1 <= hr * x_im_q;
			ir_s1 <= hi * x_re_q;
			re_s2 <= $signed({rr_s1[cfir_pkg::PROD_W-1], rr_s1})
			       - $signed({ii_s1[cfir_pkg::PROD_W-1], ii_s1});
			im_s2 <= $signed({ri_s1[cfir_pkg::PROD_W-1], ri_s1})
			       + $signed({ir_s1[cfir_pkg::PROD_W-1], ir_s1});
		end
	end

	assign x_re    = x_re_q;
	assign x_im    = x_im_q;
	assign prod_re = re_s2;
	assign prod_im = im_s2;

endmodule

### design/cfir_tree.sv
module cfir_tree #(
	parameter int LEAVES = 64
) (
	input  logic           clk,
	input  logic           advance,
	input  cfir_pkg::acc_t leaf_re [LEAVES],
	input  cfir_pkg::acc_t leaf_im [LEAVES],
	output cfir_pkg::acc_t root_re,
	output cfir_pkg::acc_t root_im
);

	// Heap layout: node i sums nodes 2i and 2i+1, the bottom row sums leaves
	cfir_pkg::acc_t node_re_q [1:LEAVES-1];
	cfir_pkg::acc_t node_im_q [1:LEAVES-1];

	for (genvar i = 1; i < LEAVES; i++) begin : g_node
		if (i >= LEAVES / 2) begin : g_bottom
			always_ff @(posedge clk) begin
				if (advance) begin
					node_re_q[i] <= leaf_re[2*i-LEAVES] + leaf_re[2*i-LEAVES+1];
					node_im_q[i] <= leaf_im[2*i-LEAVES] + leaf_im[2*i-LEAVES+1];
				end
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				if (advance) begin
					node_re_q[i] <= node_re_q[2*i] + node_re_q[2*i+1];
					node_im_q[i] <= node_im_q[2*i] + node_im_q[2*i+1];
				end
			end
		end
	end

	assign root_re = node_re_q[1];
	assign root_im = node_im_q[1];

endmodule

### design/complex_fir_filter_same.sv
// Channel   Handshake            Payload
// config    tap_count_we         tap_count
// input     in_valid/in_ready    command, tap_index, data_re, data_im, frame_last
// output    out_valid/out_ready  out_re, out_im, out_last
//
// One request is taken per cycle while in_ready is high; a sample's result passes
// through the delay line, product, combine, adder tree and output registers.
// A frame_last sample is followed by (taps-1)/2 flush shifts and a clear step,
// during which in_ready is low.
// Reset zeroes taps, delay line and frame counter, and sets tap_count to 1.
// While the output register holds an untaken result the whole pipeline freezes.
module complex_fir_filter_same #(
	parameter int MAX_TAPS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        tap_count_we,
	input  logic [6:0]  tap_count,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [5:0]  tap_index,
	input  logic signed [15:0] data_re,
	input  logic signed [15:0] data_im,
	input  logic        frame_last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [39:0] out_re,
	output logic signed [39:0] out_im,
	output logic        out_last
);

	localparam int CW     = $clog2(MAX_TAPS + 1);
	localparam int TCW    = (CW > cfir_pkg::CFG_W) ? CW : cfir_pkg::CFG_W;
	localparam int LEVELS = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int LEAVES = 1 << LEVELS;
	localparam int META_N = LEVELS + 3;

	typedef enum logic [1:0] {ST_RUN, ST_FLUSH, ST_CLEAR} state_t;

	typedef struct packed {
		logic emit;
		logic last;
	} meta_t;

	state_t            state_q;
	logic [cfir_pkg::CFG_W-1:0] tap_count_q;
	logic [CW-1:0]     cnt_q;
	logic [TCW-1:0]    flush_cnt_q;
	logic [TCW-1:0]    tc_ext, taps_used, shift;
	logic              advance, accept, load, sample, flush_push, flush_end;
	logic              emit, push_last;
	cfir_pkg::ctl_t    ctl;
	cfir_pkg::sample_t push_re, push_im;
	meta_t             meta_q [META_N];
	logic              out_valid_q, out_last_q;
	cfir_pkg::acc_t    out_re_q, out_im_q, root_re, root_im;

	cfir_pkg::sample_t line_re [MAX_TAPS];
	cfir_pkg::sample_t line_im [MAX_TAPS];
	cfir_pkg::csum_t   prod_re [MAX_TAPS];
	cfir_pkg::csum_t   prod_im [MAX_TAPS];
	cfir_pkg::acc_t    leaf_re [LEAVES];
	cfir_pkg::acc_t    leaf_im [LEAVES];

	// Tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= cfir_pkg::CFG_W'(1);
		end else if (tap_count_we) begin
			tap_count_q <= tap_count;
		end
	end

	// Taps in use and group-delay crop
	assign tc_ext    = TCW'(tap_count_q);
	assign taps_used = (tc_ext > TCW'(MAX_TAPS)) ? TCW'(MAX_TAPS) : tc_ext;
	assign shift     = (taps_used == '0) ? '0 : ((taps_used - TCW'(1)) >> 1);

	// Handshake and sequencing
	assign advance    = !out_valid_q || out_ready;
	assign in_ready   = advance && (state_q == ST_RUN);
	assign accept     = in_valid && in_ready;
	assign load       = accept && (command == cfir_pkg::CMD_LOAD);
	assign sample     = accept && (command == cfir_pkg::CMD_SAMPLE);
	assign flush_push = advance && (state_q == ST_FLUSH);
	assign flush_end  = (flush_cnt_q + TCW'(1)) == shift;

	assign emit      = TCW'(cnt_q) >= shift;
	assign push_last = sample ? (frame_last && (shift == '0)) : flush_end;
	assign push_re   = sample ? data_re : '0;
	assign push_im   = sample ? data_im : '0;

	assign ctl.advance = advance;
	assign ctl.push    = sample || flush_push;
	assign ctl.clear   = advance && (state_q == ST_CLEAR);

	// Frame sequencer: run, flush the tail, clear the line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			cnt_q       <= '0;
			flush_cnt_q <= '0;
		end else begin
			if (ctl.push && (cnt_q != CW'(MAX_TAPS))) begin
				cnt_q <= cnt_q + CW'(1);
			end
			case (state_q)
				ST_RUN: begin
					if (sample && frame_last) begin
						flush_cnt_q <= '0;
						state_q     <= (shift == '0) ? ST_CLEAR : ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (advance) begin
						flush_cnt_q <= flush_cnt_q + TCW'(1);
						if (flush_end) begin
							state_q <= ST_CLEAR;
						end
					end
				end
				ST_CLEAR: begin
					if (advance) begin
						cnt_q   <= '0;
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// Chain of cells: delay line, taps and products
	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
		logic tap_we;
		logic hit;

		// Index wraps modulo MAX_TAPS
		always_comb begin
			hit = 1'b0;
			for (int k = 0; k < cfir_pkg::IDX_SPAN; k++) begin
				if ((j + k * MAX_TAPS < cfir_pkg::IDX_SPAN) &&
				    (tap_index == cfir_pkg::IDX_W'(j + k * MAX_TAPS))) begin
					hit = 1'b1;
				end
			end
		end
		assign tap_we = load && hit;

		if (j == 0) begin : g_head
			cfir_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.x_in_re   (push_re),
				.x_in_im   (push_im),
				.x_re      (line_re[j]),
				.x_im      (line_im[j]),
				.tap_we    (tap_we),
				.tap_wr_re (data_re),
				.tap_wr_im (data_im),
				.use_tap   (TCW'(j) < taps_used),
				.prod_re   (prod_re[j]),
				.prod_im   (prod_im[j])
			);
		end else begin : g_body
			cfir_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.x_in_re   (line_re[j-1]),
				.x_in_im   (line_im[j-1]),
				.x_re      (line_re[j]),
				.x_im      (line_im[j]),
				.tap_we    (tap_we),
				.tap_wr_re (data_re),
				.tap_wr_im (data_im),
				.use_tap   (TCW'(j) < taps_used),
				.prod_re   (prod_re[j]),
				.prod_im   (prod_im[j])
			);
		end
	end

	// Tree leaves, sign-extended, padded with zeros
	for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
		if (j < MAX_TAPS) begin : g_used
			assign leaf_re[j] = cfir_pkg::ACC_W'(prod_re[j]);
			assign leaf_im[j] = cfir_pkg::ACC_W'(prod_im[j]);
		end else begin : g_pad
			assign leaf_re[j] = '0;
			assign leaf_im[j] = '0;
		end
	end

	cfir_tree #(
		.LEAVES (LEAVES)
	) u_tree (
		.clk     (clk),
		.advance (advance),
		.leaf_re (leaf_re),
		.leaf_im (leaf_im),
		.root_re (root_re),
		.root_im (root_im)
	);

	// Emit and last flags travel alongside the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < META_N; n++) begin
				meta_q[n] <= '0;
			end
		end else if (advance) begin
			meta_q[0].emit <= ctl.push && emit;
			meta_q[0].last <= ctl.push && push_last;
			for (int n = 1; n < META_N; n++) begin
				meta_q[n] <= meta_q[n-1];
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (advance) begin
			out_valid_q <= meta_q[META_N-1].emit;
			out_last_q  <= meta_q[META_N-1].last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_re_q <= root_re;
			out_im_q <= root_im;
		end
	end

	assign out_valid = out_valid_q;
	assign out_last  = out_last_q;
	assign out_re    = out_re_q;
	assign out_im    = out_im_q;

endmodule

### tb/cfir_output_checker.sv
module cfir_output_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       tap_count_we,
	input  logic [cfir_pkg::CFG_W-1:0] tap_count,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       command,
	input  logic [cfir_pkg::IDX_W-1:0] tap_index,
	input  cfir_pkg::sample_t          data_re,
	input  cfir_pkg::sample_t          data_im,
	input  logic                       frame_last,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  cfir_pkg::acc_t             out_re,
	input  cfir_pkg::acc_t             out_im,
	input  logic                       out_last,
	output int                         fail_count,
	output int                         pending,
	output int                         result_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		cfir_pkg::acc_t re;
		cfir_pkg::acc_t im;
		logic           last;
	} filt_out_t;

	// Expected filter outputs, oldest first
	filt_out_t expected_outputs[$];

	// Predictor state
	logic [cfir_pkg::CFG_W-1:0] taps_reg;
	cfir_pkg::sample_t          coef_re [cfir_pkg::IDX_SPAN];
	cfir_pkg::sample_t          coef_im [cfir_pkg::IDX_SPAN];
	cfir_pkg::sample_t          line_re [cfir_pkg::IDX_SPAN];
	cfir_pkg::sample_t          line_im [cfir_pkg::IDX_SPAN];
	int unsigned                frame_pos;

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH: %s", $realtime, what);
		fail_count++;
	endtask

	// Shift one sample into the delay line, form the complex sum, queue it once past the crop
	task automatic shift_and_sum(input cfir_pkg::sample_t re, input cfir_pkg::sample_t im,
			input int unsigned taps, input int unsigned shift, input logic is_last);
		longint    acc_re;
		longint    acc_im;
		int        k;
		filt_out_t o;
		for (k = cfir_pkg::IDX_SPAN - 1; k > 0; k--) begin
			line_re[k] = line_re[k-1];
			line_im[k] = line_im[k-1];
		end
		line_re[0] = re;
		line_im[0] = im;
		acc_re = 0;
		acc_im = 0;
		for (k = 0; k < int'(taps); k++) begin
			acc_re += longint'(coef_re[k]) * longint'(line_re[k])
				- longint'(coef_im[k]) * longint'(line_im[k]);
			acc_im += longint'(coef_re[k]) * longint'(line_im[k])
				+ longint'(coef_im[k]) * longint'(line_re[k]);
		end
		if (frame_pos >= shift) begin
			o.re   = acc_re[cfir_pkg::ACC_W-1:0];
			o.im   = acc_im[cfir_pkg::ACC_W-1:0];
			o.last = is_last;
			expected_outputs.push_back(o);
		end
		// counter only needs to reach the crop, so it stops at the line depth
		if (frame_pos < cfir_pkg::IDX_SPAN)
			frame_pos++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int unsigned taps;
		int unsigned shift;
		int unsigned k;
		filt_out_t   e;
		if (!arst_n) begin
			taps_reg = 1;
			for (int i = 0; i < cfir_pkg::IDX_SPAN; i++) begin
				coef_re[i] = '0;
				coef_im[i] = '0;
				line_re[i] = '0;
				line_im[i] = '0;
			end
			frame_pos = 0;
			expected_outputs.delete();
			fail_count = 0;
			result_count = 0;
			pending <= 0;
		end else begin
			// result side: compare against the oldest expectation
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_outputs.size() == 0) begin
					flag_mismatch($sformatf("output %0d arrived with nothing expected",
						result_count));
				end else begin
					e = expected_outputs.pop_front();
					if (out_re !== e.re)
						flag_mismatch($sformatf("output %0d out_re %0d, predicted %0d",
							result_count, out_re, e.re));
					if (out_im !== e.im)
						flag_mismatch($sformatf("output %0d out_im %0d, predicted %0d",
							result_count, out_im, e.im));
					if (out_last !== e.last)
						flag_mismatch($sformatf("output %0d out_last %b, predicted %b",
							result_count, out_last, e.last));
				end
			end

			if (tap_count_we)
				taps_reg = tap_count;

			// request side
			if (in_valid && in_ready) begin
				if (command == cfir_pkg::CMD_LOAD) begin
					coef_re[tap_index] = data_re;
					coef_im[tap_index] = data_im;
				end else begin
					taps  = (taps_reg > cfir_pkg::IDX_SPAN) ? cfir_pkg::IDX_SPAN : taps_reg;
					shift = (taps != 0) ? (taps - 1) / 2 : 0;
					shift_and_sum(data_re, data_im, taps, shift, frame_last && shift == 0);
					if (frame_last) begin
						// flush the tail with zeros, then clear for the next frame
						for (k = 0; k < shift; k++)
							shift_and_sum('0, '0, taps, shift, k + 1 == shift);
						for (int i = 0; i < cfir_pkg::IDX_SPAN; i++) begin
							line_re[i] = '0;
							line_im[i] = '0;
						end
						frame_pos = 0;
					end
				end
			end
			pending <= expected_outputs.size();
		end
	end

endmodule

### tb/tb_complex_fir_filter_same.sv
module tb_complex_fir_filter_same;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM = 480;
	localparam int SETTLE   = 64;
	localparam int LIMIT    = 400000;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       tap_count_we;
	logic [cfir_pkg::CFG_W-1:0] tap_count;
	logic                       in_valid;
	logic                       in_ready;
	logic                       command;
	logic [cfir_pkg::IDX_W-1:0] tap_index;
	cfir_pkg::sample_t          data_re;
	cfir_pkg::sample_t          data_im;
	logic                       frame_last;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	cfir_pkg::acc_t             out_re;
	cfir_pkg::acc_t             out_im;
	logic                       out_last;

	int fail_count;
	int pending;
	int result_count;
	int cycle_count = 0;
	int loads_sent  = 0;
	int samples_sent = 0;
	int frames_sent = 0;
	bit idling = 1'b1;

	complex_fir_filter_same dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.tap_count_we (tap_count_we),
		.tap_count    (tap_count),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.tap_index    (tap_index),
		.data_re      (data_re),
		.data_im      (data_im),
		.frame_last   (frame_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_re       (out_re),
		.out_im       (out_im),
		.out_last     (out_last)
	);

	cfir_output_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.tap_count_we (tap_count_we),
		.tap_count    (tap_count),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.tap_index    (tap_index),
		.data_re      (data_re),
		.data_im      (data_im),
		.frame_last   (frame_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_re       (out_re),
		.out_im       (out_im),
		.out_last     (out_last),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	always #5 clk = ~clk;

	// result side back-pressure
	always @(posedge clk) begin
		out_ready <= idling ? ($urandom_range(0, 99) >= 11) : 1'b1;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("Timed out after %0d cycles with %0d outputs outstanding",
				cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly full random, with a fair share of the Q1.15 extremes and zero
	function automatic cfir_pkg::sample_t pick_word();
		case ($urandom_range(0, 7))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			default: return cfir_pkg::sample_t'($urandom);
		endcase
	endfunction

	// one request: optional idle gap, then hold valid until taken
	task automatic send(input logic cmd, input logic [cfir_pkg::IDX_W-1:0] idx,
			input cfir_pkg::sample_t re, input cfir_pkg::sample_t im, input logic last);
		while (idling && $urandom_range(0, 99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		tap_index  <= idx;
		data_re    <= re;
		data_im    <= im;
		frame_last <= last;
		do @(posedge clk); while (!in_ready);
		if (cmd == cfir_pkg::CMD_LOAD) begin
			loads_sent++;
		end else begin
			samples_sent++;
			if (last)
				frames_sent++;
		end
	endtask

	// hold off until every predicted output is back, then let the pipe empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_taps(input logic [cfir_pkg::CFG_W-1:0] v);
		tap_count_we <= 1'b1;
		tap_count    <= v;
		@(posedge clk);
		tap_count_we <= 1'b0;
	endtask

	// a frame of samples, with tap loads slipped in now and then
	task automatic send_frame(input int len);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < 10)
				send(cfir_pkg::CMD_LOAD, cfir_pkg::IDX_W'($urandom), pick_word(),
					pick_word(), 1'($urandom_range(0, 1)));
			send(cfir_pkg::CMD_SAMPLE, cfir_pkg::IDX_W'($urandom), pick_word(),
				pick_word(), i == len - 1);
		end
	endtask

	initial begin
		int                         phase;
		int                         start_count;
		logic [cfir_pkg::CFG_W-1:0] tc;
		arst_n       = 1'b0;
		tap_count_we = 1'b0;
		tap_count    = '0;
		in_valid     = 1'b0;
		command      = cfir_pkg::CMD_SAMPLE;
		tap_index    = '0;
		data_re      = '0;
		data_im      = '0;
		frame_last   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single tap from reset: extreme coefficients, frame_last on a load is ignored
		send(cfir_pkg::CMD_LOAD, 6'd0, 16'sh7fff, 16'sh8000, 1'b0);
		send(cfir_pkg::CMD_LOAD, 6'd63, 16'sh8000, 16'sh8000, 1'b1);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh8000, 16'sh8000, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd63, 16'sh7fff, 16'sh7fff, 1'b1);
		drain();

		// four taps: one sample of crop, a load mid-frame, then a one-sample frame
		set_taps(7'd4);
		send(cfir_pkg::CMD_LOAD, 6'd1, 16'sh8000, 16'sh7fff, 1'b0);
		send(cfir_pkg::CMD_LOAD, 6'd2, 16'sh4000, 16'she000, 1'b0);
		send(cfir_pkg::CMD_LOAD, 6'd3, 16'sh0001, 16'shffff, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh7fff, 16'sh8000, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh8000, 16'sh7fff, 1'b0);
		send(cfir_pkg::CMD_LOAD, 6'd1, 16'sh1234, 16'shffff, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh5555, 16'shaaaa, 1'b1);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh7fff, 16'sh7fff, 1'b1);
		drain();

		// no taps in use: all outputs zero
		set_taps(7'd0);
		send(cfir_pkg::CMD_SAMPLE, 6'd5, 16'sh7fff, 16'sh8000, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd5, 16'sh8000, 16'sh8000, 1'b1);
		drain();

		// count above the line depth clamps to all taps; one sample gives the full flush
		set_taps(7'd127);
		send(cfir_pkg::CMD_LOAD, 6'd63, 16'sh8000, 16'sh8000, 1'b0);
		send(cfir_pkg::CMD_SAMPLE, 6'd0, 16'sh8000, 16'sh8000, 1'b1);
		drain();

		// random phases: new tap count, some reloads, a few frames, then drain
		phase = 0;
		start_count = loads_sent + samples_sent;
		while (loads_sent + samples_sent - start_count < N_RANDOM) begin
			idling = (phase != 3);
			case (phase % 6)
				0: tc = 7'd1;
				1: tc = 7'd127;
				2: tc = 7'd0;
				3: tc = 7'd64;
				default: tc = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(1, 12));
			endcase
			set_taps(tc);
			repeat ($urandom_range(2, 8))
				send(cfir_pkg::CMD_LOAD, cfir_pkg::IDX_W'($urandom), pick_word(),
					pick_word(), 1'($urandom_range(0, 1)));
			// mostly short frames; now and then one long enough to saturate the counter
			repeat ($urandom_range(2, 5))
				send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(65, 72)
					: $urandom_range(1, 10));
			drain();
			phase++;
		end
		idling = 1'b1;

		$display("Covered %0d tap loads and %0d samples over %0d frames, tap counts 0..127,",
			loads_sent, samples_sent, frames_sent);
		$display("with %0d complex outputs checked against the predicted sums.", result_count);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
